// ===== rtl/core/acu_pkg.sv =====
// acu_pkg: shared constants, types and event codes for the arithmetic coder interval update
// no dependencies
package acu_pkg;

    localparam int STATE_BITS = 32;
    localparam int FREQ_W     = 31;
    localparam int PROD_W     = STATE_BITS + FREQ_W + 1;
    localparam int CNT_W      = $clog2(PROD_W + 1);
    localparam int EVT_CNT_W  = $clog2(STATE_BITS + 1);

    localparam logic [STATE_BITS-1:0] STATE_MASK = {STATE_BITS{1'b1}};
    localparam logic [STATE_BITS-1:0] HALF_BIT   = {1'b1, {(STATE_BITS-1){1'b0}}};
    localparam logic [STATE_BITS-1:0] QTR_BIT    = HALF_BIT >> 1;
    localparam logic [STATE_BITS:0]   MAX_TOTAL  = {1'b0, QTR_BIT} + (STATE_BITS+1)'(2);

    typedef enum logic [1:0] {
        EV_SHIFT     = 2'd0,
        EV_UNDERFLOW = 2'd1,
        EV_DONE      = 2'd2,
        EV_ERROR     = 2'd3
    } t_event;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_HI,
        ST_DIV_HI,
        ST_MUL_LO,
        ST_DIV_LO,
        ST_BOUNDS,
        ST_SHIFT,
        ST_UNDER,
        ST_DONE,
        ST_ERROR
    } t_state;

    // request/status between sequencer and shared divider
    typedef struct packed {
        logic start;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ===== rtl/core/acu_stream_if.sv =====
// acu_stream_if: valid/ready channels for input symbols and result events
// depends on acu_pkg
interface acu_in_if;
    import acu_pkg::*;
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] cum_low;
    logic [FREQ_W-1:0] cum_high;
    logic [FREQ_W-1:0] freq_total;
    modport source (output valid, cum_low, cum_high, freq_total, input ready);
    modport sink   (input valid, cum_low, cum_high, freq_total, output ready);
endinterface

interface acu_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic        shift_bit;
    logic [31:0] low_bound;
    logic [31:0] high_bound;
    logic        last;
    modport source (output valid, event_kind, shift_bit, low_bound, high_bound, last,
                    input ready);
    modport sink   (input valid, event_kind, shift_bit, low_bound, high_bound, last,
                    output ready);
endinterface

// ===== rtl/core/acu_divider.sv =====
// acu_divider: restoring radix-2 divider, one quotient bit per cycle
// depends on acu_pkg
module acu_divider
    import acu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [FREQ_W-1:0] i_divisor,
    output t_div_sts          o_sts,
    output logic [PROD_W-1:0] o_quotient
);

    logic [PROD_W-1:0] r_quo, n_quo;
    logic [FREQ_W:0]   r_rem, n_rem;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [FREQ_W+1:0] w_trial;

    // one shift-subtract step per cycle
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem, r_quo[PROD_W-1]} - {2'b00, i_divisor};
        if (i_req.start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_cnt  = CNT_W'(PROD_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[FREQ_W+1]) begin
                n_rem = w_trial[FREQ_W:0];
                n_quo = {r_quo[PROD_W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[FREQ_W-1:0], r_quo[PROD_W-1]};
                n_quo = {r_quo[PROD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/core/arith_coder_interval_update.sv =====
// arith_coder_interval_update: interval narrowing and normalization sequencer
// depends on acu_pkg, acu_stream_if, acu_divider
//
// channel   dir  handshake     payload
// s_in      in   valid/ready   cum_low, cum_high, freq_total
// m_out     out  valid/ready   event_kind, shift_bit, low_bound, high_bound, last
//
// ready returns in the cycle after the last item is taken.
// the shared 64-step restoring divider runs twice per symbol.
// ready is low from acceptance until the last item leaves; stalls on m_out hold state.
// synchronous active-low reset sets low to zero and high to all ones.
module arith_coder_interval_update
    import acu_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    acu_in_if.sink   s_in,
    acu_out_if.source m_out
);

    t_state r_state, n_state;
    logic [STATE_BITS-1:0] r_low, n_low, r_high, n_high;
    logic [STATE_BITS-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [STATE_BITS:0]   r_ran, n_ran;
    logic [FREQ_W-1:0]     r_clo, n_clo, r_chi, n_chi, r_tot, n_tot;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic [PROD_W-1:0]     r_qhi, n_qhi;
    logic [EVT_CNT_W-1:0]  r_n, n_n;
    logic [FREQ_W-1:0]     w_mul_op;
    logic [PROD_W-1:0]     w_mul;
    t_div_req              w_req;
    t_div_sts              w_sts;
    logic [PROD_W-1:0]     w_quo;
    logic                  w_bad;
    logic                  w_out_go;

    acu_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_dividend (r_prod),
        .i_divisor  (r_tot),
        .o_sts      (w_sts),
        .o_quotient (w_quo)
    );

    // shared multiplier: cum bound times range
    assign w_mul_op = (r_state == ST_MUL_HI) ? r_chi : r_clo;
    assign w_mul    = PROD_W'(w_mul_op) * PROD_W'(r_ran);

    assign w_bad = (s_in.cum_low >= s_in.cum_high) || (s_in.cum_high > s_in.freq_total)
                || (s_in.freq_total == '0)
                || ({1'b0, {(STATE_BITS+1-FREQ_W){1'b0}}, s_in.freq_total} >
                    {1'b0, MAX_TOTAL});

    assign s_in.ready = (r_state == ST_IDLE);
    assign w_out_go   = m_out.ready;

    // sequencer next state and outputs
    always_comb begin
        n_state = r_state;
        n_low = r_low; n_high = r_high;
        n_lo = r_lo; n_hi = r_hi; n_ran = r_ran;
        n_clo = r_clo; n_chi = r_chi; n_tot = r_tot;
        n_prod = r_prod; n_qhi = r_qhi; n_n = r_n;
        w_req.start = 1'b0;
        m_out.valid = 1'b0;
        m_out.event_kind = EV_SHIFT;
        m_out.shift_bit = 1'b0;
        m_out.low_bound = '0;
        m_out.high_bound = '0;
        m_out.last = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_in.valid) begin
                    n_clo = s_in.cum_low; n_chi = s_in.cum_high; n_tot = s_in.freq_total;
                    n_n = '0;
                    if (w_bad) begin
                        n_state = ST_ERROR;
                    end else begin
                        n_ran = (r_high < r_low) ? (STATE_BITS+1)'(1)
                              : {1'b0, r_high} - {1'b0, r_low} + (STATE_BITS+1)'(1);
                        n_state = ST_MUL_HI;
                    end
                end
            end
            ST_MUL_HI: begin
                n_prod = w_mul;
                w_req.start = 1'b0;
                n_state = ST_DIV_HI;
            end
            ST_DIV_HI: begin
                if (!w_sts.busy && !w_sts.done) begin
                    w_req.start = 1'b1;
                end else if (w_sts.done) begin
                    n_qhi = w_quo;
                    n_state = ST_MUL_LO;
                end
            end
            ST_MUL_LO: begin
                n_prod = w_mul;
                n_state = ST_DIV_LO;
            end
            ST_DIV_LO: begin
                if (!w_sts.busy && !w_sts.done) begin
                    w_req.start = 1'b1;
                end else if (w_sts.done) begin
                    n_prod = w_quo;
                    n_state = ST_BOUNDS;
                end
            end
            ST_BOUNDS: begin
                n_hi = r_low + r_qhi[STATE_BITS-1:0] - STATE_BITS'(1);
                n_lo = r_low + r_prod[STATE_BITS-1:0];
                n_state = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (((r_lo ^ r_hi) & HALF_BIT) == '0 && r_n != EVT_CNT_W'(STATE_BITS)) begin
                    m_out.valid = 1'b1;
                    m_out.event_kind = EV_SHIFT;
                    m_out.shift_bit = r_lo[STATE_BITS-1];
                    if (w_out_go) begin
                        n_n = r_n + EVT_CNT_W'(1);
                        n_lo = r_lo << 1;
                        n_hi = (r_hi << 1) | STATE_BITS'(1);
                    end
                end else begin
                    n_state = ST_UNDER;
                end
            end
            ST_UNDER: begin
                if ((r_lo & ~r_hi & QTR_BIT) != '0 && r_n != EVT_CNT_W'(STATE_BITS)) begin
                    m_out.valid = 1'b1;
                    m_out.event_kind = EV_UNDERFLOW;
                    if (w_out_go) begin
                        n_n = r_n + EVT_CNT_W'(1);
                        n_lo = (r_lo << 1) ^ HALF_BIT;
                        n_hi = ((r_hi ^ HALF_BIT) << 1) | HALF_BIT | STATE_BITS'(1);
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                m_out.valid = 1'b1;
                m_out.event_kind = EV_DONE;
                m_out.low_bound = r_lo;
                m_out.high_bound = r_hi;
                m_out.last = 1'b1;
                if (w_out_go) begin
                    n_low = r_lo; n_high = r_hi;
                    n_state = ST_IDLE;
                end
            end
            ST_ERROR: begin
                m_out.valid = 1'b1;
                m_out.event_kind = EV_ERROR;
                m_out.last = 1'b1;
                if (w_out_go) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_low   <= '0;
            r_high  <= STATE_MASK;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_low   <= n_low;
            r_high  <= n_high;
            r_n     <= n_n;
        end
        r_lo <= n_lo; r_hi <= n_hi; r_ran <= n_ran;
        r_clo <= n_clo; r_chi <= n_chi; r_tot <= n_tot;
        r_prod <= n_prod; r_qhi <= n_qhi;
    end

endmodule
